### sv/hfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_pkg
// shared constants, result codes and the crc-32 byte update for the
// ascii-hex frame parser
// ----------------------------------------------------------------------------
package hfp_pkg;

   // frame delimiters and fixed crc bytes
   localparam logic [7:0] CHAR_LT    = 8'h3C;   // '<'
   localparam logic [7:0] CHAR_GT    = 8'h3E;   // '>'
   localparam logic [7:0] CHAR_BANG  = 8'h21;   // '!'
   localparam logic [7:0] CHAR_COLON = 8'h3A;   // ':'
   localparam logic [7:0] CHAR_AT    = 8'h40;   // '@'
   localparam logic [7:0] CHAR_A     = 8'h41;   // 'A'
   localparam logic [7:0] CHAR_F     = 8'h46;   // 'F'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;   // '9'
   localparam logic [7:0] ALPHA_OFS  = 8'h37;   // 'A' - 10
   localparam logic [7:0] DIGIT_MAX  = 8'h0F;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
   localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

   typedef enum logic [3:0] {
      STATUS_NONE       = 4'd0,
      STATUS_OK         = 4'd1,
      STATUS_BAD_SEQ    = 4'd2,
      STATUS_NO_BANG    = 4'd3,
      STATUS_BAD_CMD    = 4'd4,
      STATUS_NO_COLON   = 4'd5,
      STATUS_BAD_DATA1  = 4'd6,
      STATUS_BAD_DATA2  = 4'd7,
      STATUS_BAD_DATA3  = 4'd8,
      STATUS_NO_AT      = 4'd9,
      STATUS_BAD_CHK    = 4'd10,
      STATUS_NO_GT      = 4'd11,
      STATUS_MISMATCH   = 4'd12
   } status_type;

   // reflected crc-32, one byte, eight bit steps
   function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // crc after the leading 'A' of every frame
   localparam logic [31:0] CRC_SEED = crc32_byte(CRC_INIT, CHAR_A);

endpackage

### sv/hex_frame_parser_crc32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_frame_parser_crc32
// byte-wide parser for ascii-hex frames with a crc-32 check
// ----------------------------------------------------------------------------
// Every received byte is one transaction on the req side and gives exactly one
// transaction on the rsp side. A frame is '<', 4 sequence digits, '!', 2
// command digits, ':', 16 + 4 + 4 data digits, '@', 8 checksum digits, '>'.
// '<' restarts parsing at any point. Digits are '0'-'9', 'A'-'F' and raw bytes
// 0x00-0x0F; lowercase hex is an error. Each response carries a status code
// and the current contents of all field registers, which show partially
// shifted values while a field is still arriving. Wrong bytes report their own
// error code and clear the fields (a bad sequence digit keeps them). The crc
// covers 'A', the uppercase command digits, ':', the uppercase data digits and
// a closing 'F'; at '>' it is compared with the received checksum and the
// status is ok (packet_valid set) or crc mismatch. Throughput is one byte per
// clock: the parse step and one unrolled crc byte update sit between the
// parser state registers and the response register, so a response appears the
// cycle after its byte is taken. The response register is a single stage;
// req_tready follows it, so a stalled rsp side holds off new bytes while a
// draining one keeps the full rate.
// ----------------------------------------------------------------------------
module hex_frame_parser_crc32
   import hfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // received bytes
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] rx_byte
   // parse results
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,    // [15:0] seq_out, [23:16] command_out,
                                      // [87:24] data1_out, [103:88] data2_out,
                                      // [119:104] data3_out, [151:120] checksum_out
   output logic [4:0]   rsp_tuser     // [3:0] status, [4] packet_valid
);

   // one-hot parser states
   typedef enum logic [10:0] {
      ST_WAIT  = 11'b000_0000_0001,
      ST_SEQ   = 11'b000_0000_0010,
      ST_MARK1 = 11'b000_0000_0100,
      ST_CMD   = 11'b000_0000_1000,
      ST_MARK2 = 11'b000_0001_0000,
      ST_D1    = 11'b000_0010_0000,
      ST_D2    = 11'b000_0100_0000,
      ST_D3    = 11'b000_1000_0000,
      ST_MARK3 = 11'b001_0000_0000,
      ST_CHK   = 11'b010_0000_0000,
      ST_END   = 11'b100_0000_0000
   } state_type;

   // digit counts per field
   localparam logic [4:0] LEN_SEQ  = 5'd4;
   localparam logic [4:0] LEN_CMD  = 5'd2;
   localparam logic [4:0] LEN_D1   = 5'd16;
   localparam logic [4:0] LEN_D2   = 5'd4;
   localparam logic [4:0] LEN_D3   = 5'd4;
   localparam logic [4:0] LEN_CHK  = 5'd8;

   // or in the digit, shift left unless it was the last digit of the field
   function automatic logic [63:0] take_digit(logic [63:0] acc, logic [3:0] d,
                                              logic last);
      logic [63:0] t;
      t = acc | {60'd0, d};
      return last ? t : (t << 4);
   endfunction

   // parser state
   state_type   state_ff, state_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [63:0] data1_ff, data1_in;
   logic [15:0] data2_ff, data2_in;
   logic [15:0] data3_ff, data3_in;
   logic [31:0] chk_ff, chk_in;
   logic        valid_ff, valid_in;
   logic [31:0] crc_ff, crc_in;

   // response register
   logic         rsp_valid_ff;
   status_type   rsp_status_ff;
   logic         rsp_flag_ff;
   logic [151:0] rsp_data_ff;

   status_type  status_in;
   logic        advance;
   logic [7:0]  dec_byte;
   logic        is_digit;
   logic [3:0]  nib;
   logic [7:0]  hex_char;
   logic [7:0]  crc_data;
   logic [31:0] crc_next;
   logic [31:0] crc_final;
   logic [4:0]  count_inc;
   logic        clear;
   logic [63:0] take_val;
   logic [4:0]  field_len;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;

   // byte decode: uppercase hex and decimal digits become 0-15
   always_comb begin
      dec_byte = req_tdata;
      if (req_tdata >= CHAR_A && req_tdata <= CHAR_F) begin
         dec_byte = req_tdata - ALPHA_OFS;
      end else if (req_tdata >= CHAR_ZERO && req_tdata <= CHAR_NINE) begin
         dec_byte = req_tdata - CHAR_ZERO;
      end
   end

   assign is_digit  = (dec_byte <= DIGIT_MAX);
   assign nib       = dec_byte[3:0];
   assign hex_char  = (nib < 4'd10) ? (CHAR_ZERO + {4'd0, nib}) : (ALPHA_OFS + {4'd0, nib});
   assign count_inc = count_ff + 5'd1;

   // crc byte: ':' after the command, closing 'F' at the end, else the digit
   always_comb begin
      case (state_ff)
         ST_MARK2: crc_data = CHAR_COLON;
         ST_END:   crc_data = CHAR_F;
         default:  crc_data = hex_char;
      endcase
   end

   hfp_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .crc_data  (crc_data),
      .crc_next  (crc_next),
      .crc_final (crc_final)
   );

   // accumulator of the field being received and its length
   always_comb begin
      case (state_ff)
         ST_SEQ:  begin field_len = LEN_SEQ; take_val = {48'd0, seq_ff};   end
         ST_CMD:  begin field_len = LEN_CMD; take_val = {56'd0, cmd_ff};   end
         ST_D1:   begin field_len = LEN_D1;  take_val = data1_ff;          end
         ST_D2:   begin field_len = LEN_D2;  take_val = {48'd0, data2_ff}; end
         ST_D3:   begin field_len = LEN_D3;  take_val = {48'd0, data3_ff}; end
         ST_CHK:  begin field_len = LEN_CHK; take_val = {32'd0, chk_ff};   end
         default: begin field_len = LEN_SEQ; take_val = 64'd0;             end
      endcase
      take_val = take_digit(take_val, nib, count_inc == field_len);
   end

   // parse step
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      seq_in    = seq_ff;
      cmd_in    = cmd_ff;
      data1_in  = data1_ff;
      data2_in  = data2_ff;
      data3_in  = data3_ff;
      chk_in    = chk_ff;
      valid_in  = valid_ff;
      crc_in    = crc_ff;
      status_in = STATUS_NONE;
      clear     = 1'b0;

      if (req_tdata == CHAR_LT) begin
         // start of frame from any state
         state_in = ST_SEQ;
         count_in = 5'd0;
         clear    = 1'b1;
         crc_in   = CRC_SEED;
      end else begin
         case (state_ff)
            ST_SEQ: begin
               if (is_digit) begin
                  seq_in   = take_val[15:0];
                  count_in = (count_inc == LEN_SEQ) ? 5'd0 : count_inc;
                  if (count_inc == LEN_SEQ) state_in = ST_MARK1;
               end else begin
                  // fields are kept here
                  status_in = STATUS_BAD_SEQ;
                  state_in  = ST_WAIT;
               end
            end
            ST_MARK1: begin
               if (req_tdata == CHAR_BANG) begin
                  state_in = ST_CMD;
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_NO_BANG;
                  state_in  = ST_WAIT;
               end
            end
            ST_CMD: begin
               if (is_digit) begin
                  crc_in   = crc_next;
                  cmd_in   = take_val[7:0];
                  count_in = (count_inc == LEN_CMD) ? 5'd0 : count_inc;
                  if (count_inc == LEN_CMD) state_in = ST_MARK2;
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_BAD_CMD;
                  state_in  = ST_WAIT;
               end
            end
            ST_MARK2: begin
               if (req_tdata == CHAR_COLON) begin
                  crc_in   = crc_next;
                  state_in = ST_D1;
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_NO_COLON;
                  state_in  = ST_WAIT;
               end
            end
            ST_D1: begin
               if (is_digit) begin
                  crc_in   = crc_next;
                  data1_in = take_val;
                  count_in = (count_inc == LEN_D1) ? 5'd0 : count_inc;
                  if (count_inc == LEN_D1) state_in = ST_D2;
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_BAD_DATA1;
                  state_in  = ST_WAIT;
               end
            end
            ST_D2: begin
               if (is_digit) begin
                  crc_in   = crc_next;
                  data2_in = take_val[15:0];
                  count_in = (count_inc == LEN_D2) ? 5'd0 : count_inc;
                  if (count_inc == LEN_D2) state_in = ST_D3;
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_BAD_DATA2;
                  state_in  = ST_WAIT;
               end
            end
            ST_D3: begin
               if (is_digit) begin
                  crc_in   = crc_next;
                  data3_in = take_val[15:0];
                  count_in = (count_inc == LEN_D3) ? 5'd0 : count_inc;
                  if (count_inc == LEN_D3) state_in = ST_MARK3;
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_BAD_DATA3;
                  state_in  = ST_WAIT;
               end
            end
            ST_MARK3: begin
               if (req_tdata == CHAR_AT) begin
                  state_in = ST_CHK;
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_NO_AT;
                  state_in  = ST_WAIT;
               end
            end
            ST_CHK: begin
               if (is_digit) begin
                  chk_in   = take_val[31:0];
                  count_in = (count_inc == LEN_CHK) ? 5'd0 : count_inc;
                  if (count_inc == LEN_CHK) state_in = ST_END;
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_BAD_CHK;
                  state_in  = ST_WAIT;
               end
            end
            ST_END: begin
               if (req_tdata == CHAR_GT) begin
                  // fields stay, only the verdict changes
                  if (crc_final == chk_ff) begin
                     valid_in  = 1'b1;
                     status_in = STATUS_OK;
                  end else begin
                     valid_in  = 1'b0;
                     status_in = STATUS_MISMATCH;
                  end
               end else begin
                  clear     = 1'b1;
                  status_in = STATUS_NO_GT;
               end
               state_in = ST_WAIT;
            end
            default: begin
               // idle between frames
               clear    = 1'b1;
               state_in = ST_WAIT;
            end
         endcase
      end

      if (clear) begin
         seq_in   = '0;
         cmd_in   = '0;
         data1_in = '0;
         data2_in = '0;
         data3_in = '0;
         chk_in   = '0;
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
         count_ff <= '0;
         seq_ff   <= '0;
         cmd_ff   <= '0;
         data1_ff <= '0;
         data2_ff <= '0;
         data3_ff <= '0;
         chk_ff   <= '0;
         valid_ff <= 1'b0;
         crc_ff   <= CRC_INIT;
      end else if (advance) begin
         state_ff <= state_in;
         count_ff <= count_in;
         seq_ff   <= seq_in;
         cmd_ff   <= cmd_in;
         data1_ff <= data1_in;
         data2_ff <= data2_in;
         data3_ff <= data3_in;
         chk_ff   <= chk_in;
         valid_ff <= valid_in;
         crc_ff   <= crc_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status_in;
         rsp_flag_ff   <= valid_in;
         rsp_data_ff   <= {chk_in, data3_in, data2_in, data1_in, cmd_in, seq_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_flag_ff, rsp_status_ff};

   // packet_valid is raised only on the ok transaction itself
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_flag_ff == (rsp_status_ff == STATUS_OK)))
      else $error("packet_valid disagrees with ok status");

   // every accepted byte leaves a response behind
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("accepted byte gave no response");

   // a start byte always opens the sequence field with a clean counter
   assert property (@(posedge clock) disable iff (reset)
      (advance && req_tdata == CHAR_LT) |=> (state_ff == ST_SEQ && count_ff == 5'd0
                                             && crc_ff == CRC_SEED))
      else $error("start byte did not restart the parser");

   // the digit counter never holds a full data1 field
   assert property (@(posedge clock) disable iff (reset)
      !count_ff[4])
      else $error("digit counter overran");

   // errors that clear the fields really leave them zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_NO_BANG || rsp_status_ff == STATUS_BAD_CMD
         || rsp_status_ff == STATUS_NO_COLON || rsp_status_ff == STATUS_BAD_DATA1
         || rsp_status_ff == STATUS_BAD_DATA2 || rsp_status_ff == STATUS_BAD_DATA3
         || rsp_status_ff == STATUS_NO_AT || rsp_status_ff == STATUS_BAD_CHK
         || rsp_status_ff == STATUS_NO_GT)) |-> (rsp_data_ff == '0 && !rsp_flag_ff))
      else $error("fields not cleared on error");

endmodule

### sv/hfp_crc_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_crc_byte
// combinational crc-32 update by one byte, also gives the finalised value
// ----------------------------------------------------------------------------
module hfp_crc_byte
   import hfp_pkg::*;
(
   input  logic [31:0] crc_cur,
   input  logic [7:0]  crc_data,
   output logic [31:0] crc_next,
   output logic [31:0] crc_final
);

   assign crc_next  = crc32_byte(crc_cur, crc_data);
   assign crc_final = crc_next ^ CRC_XOROUT;

endmodule

### dv/hex_frame_parser_crc32_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_frame_parser_crc32_test
// self-checking bench for the ascii-hex frame parser with crc-32 check
// ----------------------------------------------------------------------------
// Bytes are pushed into the req stream one transaction at a time. A small
// scoreboard keeps its own copy of the parser state, works out the rsp
// transaction that each accepted byte must produce and checks every field of
// the rsp stream in order. After a short directed opening, the bulk of the
// traffic is frames with random content: a minority are well formed (some
// with a deliberately wrong checksum), the rest are broken in one section,
// taken in turn so that every error code comes up, with noise bytes in
// between. Both streams idle at random and the rsp side holds off once for a
// long stretch so that the parser back-pressures its input.
// ----------------------------------------------------------------------------
module hex_frame_parser_crc32_test;
   import hfp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;   // far above the slowest legal run
   localparam int BYTE_TARGET  = 900;
   localparam int LONG_HOLD    = 400;      // rsp hold-off used for back-pressure
   localparam int MAX_IDLE     = 14;
   localparam int NUM_SECTIONS = 11;
   localparam int SEC_RESTART  = 10;       // section code for a '<' mid-frame
   localparam logic [7:0] LOWER_A = 8'h61; // lowercase hex must be rejected

   // own view of where the parser is inside a frame
   typedef enum logic [3:0] {
      PS_IDLE, PS_SEQ, PS_BANG, PS_CMD, PS_COLON, PS_DATA1, PS_DATA2, PS_DATA3,
      PS_AT, PS_CHECK, PS_CLOSE
   } parse_phase_type;

   // one rsp transaction as the parser should present it
   typedef struct {
      status_type  status;
      logic        valid;
      logic [15:0] seq;
      logic [7:0]  cmd;
      logic [63:0] data1;
      logic [15:0] data2;
      logic [15:0] data3;
      logic [31:0] chk;
   } parse_result_type;

   // -------------------------------------------------------------------------
   // scoreboard: frame-parser state plus the queue of expected responses
   // -------------------------------------------------------------------------
   class frame_scoreboard;
      parse_phase_type  phase;
      logic [4:0]       nibbles;
      logic [15:0]      seq_acc;
      logic [7:0]       cmd_acc;
      logic [63:0]      d1_acc;
      logic [15:0]      d2_acc;
      logic [15:0]      d3_acc;
      logic [31:0]      chk_acc;
      logic             frame_ok;
      logic [31:0]      crc_acc;
      parse_result_type expected_q[$];
      int               mismatches;
      int               responses;
      int               tally[16];

      function new();
         phase      = PS_IDLE;
         nibbles    = '0;
         crc_acc    = CRC_INIT;
         mismatches = 0;
         responses  = 0;
         clear_fields();
      endfunction

      // reflected crc-32, one bit per step
      static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'd0, b};
         repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
         return r;
      endfunction

      // uppercase ascii digits map to 0..15, every other byte is left alone
      static function logic [7:0] decode_byte(logic [7:0] b);
         if (b >= CHAR_A && b <= CHAR_F) begin
            return b - ALPHA_OFS;
         end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            return b - CHAR_ZERO;
         end
         return b;
      endfunction

      static function logic [7:0] nibble_char(logic [3:0] n);
         return (n < 4'd10) ? CHAR_ZERO + {4'd0, n} : ALPHA_OFS + {4'd0, n};
      endfunction

      function void clear_fields();
         seq_acc  = '0;
         cmd_acc  = '0;
         d1_acc   = '0;
         d2_acc   = '0;
         d3_acc   = '0;
         chk_acc  = '0;
         frame_ok = 1'b0;
      endfunction

      // shifts one digit into a field of n digits; true once the field is full
      function bit shift_in(inout logic [63:0] acc, input logic [3:0] d, input int n,
                            input logic [63:0] mask);
         acc     = (acc | {60'd0, d}) & mask;
         nibbles = nibbles + 5'd1;
         if (nibbles == n) begin
            nibbles = '0;
            return 1'b1;
         end
         acc = (acc << 4) & mask;
         return 1'b0;
      endfunction

      // advance the parser by one accepted byte and queue the response
      function void note_rx_byte(logic [7:0] b);
         logic [7:0]       v;
         logic             is_dig;
         logic [63:0]      t;
         logic [31:0]      final_crc;
         status_type       st;
         parse_result_type r;
         v      = decode_byte(b);
         is_dig = (v <= DIGIT_MAX);
         st     = STATUS_NONE;
         if (v == CHAR_LT) begin
            // restart from anywhere, crc seeded with the implicit 'A'
            phase   = PS_SEQ;
            nibbles = '0;
            clear_fields();
            crc_acc = crc_update(CRC_INIT, CHAR_A);
         end else begin
            case (phase)
               PS_SEQ: begin
                  if (is_dig) begin
                     t = {48'd0, seq_acc};
                     if (shift_in(t, v[3:0], 4, 64'hFFFF)) phase = PS_BANG;
                     seq_acc = t[15:0];
                  end else begin
                     // the one error that leaves the fields alone
                     st    = STATUS_BAD_SEQ;
                     phase = PS_IDLE;
                  end
               end
               PS_BANG: begin
                  if (v == CHAR_BANG) begin
                     phase = PS_CMD;
                  end else begin
                     clear_fields();
                     st    = STATUS_NO_BANG;
                     phase = PS_IDLE;
                  end
               end
               PS_CMD: begin
                  if (is_dig) begin
                     crc_acc = crc_update(crc_acc, nibble_char(v[3:0]));
                     t = {56'd0, cmd_acc};
                     if (shift_in(t, v[3:0], 2, 64'hFF)) phase = PS_COLON;
                     cmd_acc = t[7:0];
                  end else begin
                     clear_fields();
                     st    = STATUS_BAD_CMD;
                     phase = PS_IDLE;
                  end
               end
               PS_COLON: begin
                  if (v == CHAR_COLON) begin
                     crc_acc = crc_update(crc_acc, CHAR_COLON);
                     phase   = PS_DATA1;
                  end else begin
                     clear_fields();
                     st    = STATUS_NO_COLON;
                     phase = PS_IDLE;
                  end
               end
               PS_DATA1: begin
                  if (is_dig) begin
                     crc_acc = crc_update(crc_acc, nibble_char(v[3:0]));
                     if (shift_in(d1_acc, v[3:0], 16, '1)) phase = PS_DATA2;
                  end else begin
                     clear_fields();
                     st    = STATUS_BAD_DATA1;
                     phase = PS_IDLE;
                  end
               end
               PS_DATA2: begin
                  if (is_dig) begin
                     crc_acc = crc_update(crc_acc, nibble_char(v[3:0]));
                     t = {48'd0, d2_acc};
                     if (shift_in(t, v[3:0], 4, 64'hFFFF)) phase = PS_DATA3;
                     d2_acc = t[15:0];
                  end else begin
                     clear_fields();
                     st    = STATUS_BAD_DATA2;
                     phase = PS_IDLE;
                  end
               end
               PS_DATA3: begin
                  if (is_dig) begin
                     crc_acc = crc_update(crc_acc, nibble_char(v[3:0]));
                     t = {48'd0, d3_acc};
                     if (shift_in(t, v[3:0], 4, 64'hFFFF)) phase = PS_AT;
                     d3_acc = t[15:0];
                  end else begin
                     clear_fields();
                     st    = STATUS_BAD_DATA3;
                     phase = PS_IDLE;
                  end
               end
               PS_AT: begin
                  if (v == CHAR_AT) begin
                     phase = PS_CHECK;
                  end else begin
                     clear_fields();
                     st    = STATUS_NO_AT;
                     phase = PS_IDLE;
                  end
               end
               PS_CHECK: begin
                  if (is_dig) begin
                     t = {32'd0, chk_acc};
                     if (shift_in(t, v[3:0], 8, 64'hFFFF_FFFF)) phase = PS_CLOSE;
                     chk_acc = t[31:0];
                  end else begin
                     clear_fields();
                     st    = STATUS_BAD_CHK;
                     phase = PS_IDLE;
                  end
               end
               PS_CLOSE: begin
                  if (v == CHAR_GT) begin
                     // crc closes with the implicit 'F'; fields stay either way
                     final_crc = crc_update(crc_acc, CHAR_F) ^ CRC_XOROUT;
                     frame_ok  = (final_crc == chk_acc);
                     st        = frame_ok ? STATUS_OK : STATUS_MISMATCH;
                  end else begin
                     clear_fields();
                     st = STATUS_NO_GT;
                  end
                  phase = PS_IDLE;
               end
               default: begin
                  // idle: anything but '<' wipes the fields
                  clear_fields();
                  phase = PS_IDLE;
               end
            endcase
         end
         r.status = st;
         r.valid  = frame_ok;
         r.seq    = seq_acc;
         r.cmd    = cmd_acc;
         r.data1  = d1_acc;
         r.data2  = d2_acc;
         r.data3  = d3_acc;
         r.chk    = chk_acc;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // check one accepted rsp transaction against the oldest expectation
      function void check_response(logic [151:0] d, logic [4:0] u);
         parse_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none actual tdata %h tuser %h",
                     $time, d, u);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         responses++;
         tally[e.status]++;
         compare_field("status",       64'(e.status), 64'(u[3:0]));
         compare_field("packet_valid", 64'(e.valid),  64'(u[4]));
         compare_field("seq_out",      64'(e.seq),    64'(d[15:0]));
         compare_field("command_out",  64'(e.cmd),    64'(d[23:16]));
         compare_field("data1_out",    e.data1,       d[87:24]);
         compare_field("data2_out",    64'(e.data2),  64'(d[103:88]));
         compare_field("data3_out",    64'(e.data3),  64'(d[119:104]));
         compare_field("checksum_out", 64'(e.chk),    64'(d[151:120]));
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and the block under test
   // -------------------------------------------------------------------------
   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'd0;   // [7:0] rx_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;           // [15:0] seq_out, [23:16] command_out,
                                      // [87:24] data1_out, [103:88] data2_out,
                                      // [119:104] data3_out, [151:120] checksum_out
   logic [4:0]   rsp_tuser;           // [3:0] status, [4] packet_valid

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   hex_frame_parser_crc32 u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   frame_scoreboard sb;
   int              bytes_sent      = 0;
   int              frames_sent     = 0;
   int              req_idle_max    = MAX_IDLE;
   int              rsp_idle_max    = MAX_IDLE;
   bit              hold_off_request = 1'b0;
   int              next_section    = 0;
   int              cycle_count     = 0;
   logic [7:0]      frame_bytes[$];

   // byte offsets of each frame section and their lengths; the single-byte
   // sections are the delimiters, the others are digit fields
   int sec_start[10] = '{1, 5, 6, 8, 9, 25, 29, 33, 34, 42};
   int sec_len[10]   = '{4, 1, 2, 1, 16, 4, 4, 1, 8, 1};

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, sb.outstanding());
         $display("** hex_frame_parser_crc32: FAILED **");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // req side driver
   // -------------------------------------------------------------------------
   // idles for a random number of cycles, offers the byte and holds it until
   // the transaction completes; tvalid stays high across back-to-back bytes
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // appends n digits of val, top nibble first; now and then as a raw
   // 0x00-0x0f byte instead of the ascii character
   function automatic void put_digits(logic [63:0] val, int n);
      logic [3:0] nib;
      for (int i = n - 1; i >= 0; i--) begin
         nib = val[4*i +: 4];
         frame_bytes.push_back(($urandom_range(0, 4) == 0) ? {4'd0, nib}
                               : frame_scoreboard::nibble_char(nib));
      end
   endfunction

   // one frame with random content; either well formed (sometimes with a
   // flipped checksum bit) or broken in the next section in turn and cut short
   task automatic send_random_frame();
      logic [15:0] seq_v;
      logic [7:0]  cmd_v;
      logic [63:0] d1_v;
      logic [15:0] d2_v;
      logic [15:0] d3_v;
      logic [95:0] data_all;
      logic [31:0] crc_v;
      logic [7:0]  bad;
      int          fill;
      int          sec;
      int          pos;
      bit          broken;
      fill  = $urandom_range(0, 5);
      seq_v = 16'($urandom);
      cmd_v = 8'($urandom);
      d1_v  = {$urandom, $urandom};
      d2_v  = 16'($urandom);
      d3_v  = 16'($urandom);
      if (fill == 0) begin
         {seq_v, cmd_v, d1_v, d2_v, d3_v} = '0;
      end else if (fill == 1) begin
         {seq_v, cmd_v, d1_v, d2_v, d3_v} = '1;
      end

      // checksum over the same characters the parser feeds its crc
      data_all = {d1_v, d2_v, d3_v};
      crc_v = frame_scoreboard::crc_update(CRC_INIT, CHAR_A);
      crc_v = frame_scoreboard::crc_update(crc_v, frame_scoreboard::nibble_char(cmd_v[7:4]));
      crc_v = frame_scoreboard::crc_update(crc_v, frame_scoreboard::nibble_char(cmd_v[3:0]));
      crc_v = frame_scoreboard::crc_update(crc_v, CHAR_COLON);
      for (int i = 23; i >= 0; i--) begin
         crc_v = frame_scoreboard::crc_update(crc_v,
                    frame_scoreboard::nibble_char(data_all[4*i +: 4]));
      end
      crc_v = frame_scoreboard::crc_update(crc_v, CHAR_F) ^ CRC_XOROUT;

      broken = ($urandom_range(0, 9) < 6);
      if (!broken && $urandom_range(0, 3) == 0) begin
         crc_v ^= 32'd1 << $urandom_range(0, 31);
      end

      frame_bytes.delete();
      frame_bytes.push_back(CHAR_LT);
      put_digits({48'd0, seq_v}, 4);
      frame_bytes.push_back(CHAR_BANG);
      put_digits({56'd0, cmd_v}, 2);
      frame_bytes.push_back(CHAR_COLON);
      put_digits(d1_v, 16);
      put_digits({48'd0, d2_v}, 4);
      put_digits({48'd0, d3_v}, 4);
      frame_bytes.push_back(CHAR_AT);
      put_digits({32'd0, crc_v}, 8);
      frame_bytes.push_back(CHAR_GT);

      if (broken) begin
         sec          = next_section;
         next_section = (next_section + 1) % NUM_SECTIONS;
         if (sec == SEC_RESTART) begin
            // a fresh start byte in the middle of a frame
            pos = $urandom_range(1, 42);
            bad = CHAR_LT;
         end else begin
            pos = sec_start[sec] + $urandom_range(0, sec_len[sec] - 1);
            if (sec_len[sec] > 1 && $urandom_range(0, 2) == 0) begin
               bad = LOWER_A + 8'($urandom_range(0, 5));
            end else if (sec_len[sec] > 1) begin
               do bad = 8'($urandom);
               while (frame_scoreboard::decode_byte(bad) <= DIGIT_MAX || bad == CHAR_LT);
            end else begin
               do bad = 8'($urandom);
               while (bad == frame_bytes[pos] || bad == CHAR_LT);
            end
         end
         frame_bytes[pos] = bad;
         frame_bytes = frame_bytes[0:pos];
      end

      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
      frames_sent++;
   endtask

   // -------------------------------------------------------------------------
   // rsp side: random ready gaps, one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = $urandom_range(0, rsp_idle_max);
         if (hold_off_request) begin
            // long stall: the single response stage fills and req_tready drops
            hold             = LONG_HOLD;
            hold_off_request = 1'b0;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_response(rsp_tdata, rsp_tuser);
         // switch between bursts with no idling and idling ones
         if ($urandom_range(0, 39) == 0) rsp_idle_max = (rsp_idle_max == 0) ? MAX_IDLE : 0;
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      int guard;
      int noise;
      int errs;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // idle noise: extreme bytes and lowercase while waiting for a start
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(LOWER_A);
      // bad sequence digit after two digits, partial sequence must be kept
      send_text("<12");
      send_byte(LOWER_A + 8'd6);
      // raw-byte digits at both extremes, then a missing '!'
      send_byte(CHAR_LT);
      send_byte(8'h0F);
      send_byte(8'h00);
      send_text("F9");
      send_byte(8'h80);
      // lowercase command digit
      send_text("<0000!");
      send_byte(LOWER_A + 8'd5);

      // random frames with noise in between
      while (bytes_sent < BYTE_TARGET) begin
         req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
         if (frames_sent == 6) begin
            // keep offering at full rate while the rsp side stalls
            hold_off_request = 1'b1;
            req_idle_max     = 0;
         end
         noise = $urandom_range(0, 2);
         repeat (noise) send_byte(8'($urandom));
         send_random_frame();
      end
      req_tvalid <= 1'b0;

      // drain, then allow for the registered response
      guard = 0;
      while (sb.outstanding() > 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (sb.outstanding() > 0) begin
         $display("%0t: %0d responses never arrived, expected 0 actual %0d",
                  $time, sb.outstanding(), sb.outstanding());
         sb.mismatches++;
      end

      errs = sb.responses - sb.tally[STATUS_NONE] - sb.tally[STATUS_OK]
             - sb.tally[STATUS_MISMATCH];
      $display("run covered %0d bytes in %0d random frames plus directed cases",
               bytes_sent, frames_sent);
      $display("%0d responses checked: %0d ok, %0d crc mismatch, %0d parse errors",
               sb.responses, sb.tally[STATUS_OK], sb.tally[STATUS_MISMATCH], errs);
      if (sb.mismatches == 0) begin
         $display("** hex_frame_parser_crc32: PASSED **");
      end else begin
         $display("** hex_frame_parser_crc32: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
sv/hfp_pkg.sv
sv/hfp_crc_byte.sv
sv/hex_frame_parser_crc32.sv
dv/hex_frame_parser_crc32_test.sv
